@@ rtl/core/ssort_pkg.sv @@
// Shared constants and types for the stable ascending sorter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ssort_pkg;

    localparam int DEPTH  = 64;
    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    // what one cell shows to its neighbours
    typedef struct packed {
        logic  occ;
        logic  gt;
        word_t value;
    } cell_link_t;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic  insert;
        logic  drain;
        word_t new_value;
    } cell_cmd_t;

endpackage

@@ rtl/core/ssort_cell.sv @@
// One compare-and-shift cell of the sorter chain.
// Depends on ssort_pkg for the link and command structs.
`timescale 1ns / 1ps

module ssort_cell
    import ssort_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_cmd_t  cmd,
    input  cell_link_t prev_link,
    input  cell_link_t next_link,
    output cell_link_t link
);

    logic  occ_reg;
    logic  occ_next;
    word_t value_reg;
    word_t value_next;
    logic  gt;
    logic  take;

    assign gt   = occ_reg && (value_reg > cmd.new_value);
    // take a value when displaced, or when this is the first free cell
    assign take = gt || (!occ_reg && prev_link.occ);

    always_comb
    begin
        occ_next   = occ_reg;
        value_next = value_reg;
        if (cmd.drain)
        begin
            occ_next   = next_link.occ;
            value_next = next_link.value;
        end
        else if (cmd.insert && take)
        begin
            occ_next   = 1'b1;
            value_next = prev_link.gt ? prev_link.value : cmd.new_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.occ   = occ_reg;
    assign link.gt    = gt;
    assign link.value = value_reg;

endmodule

@@ rtl/core/stable_ascending_sorter.sv @@
// Stable ascending sorter: a chain of DEPTH compare-and-shift cells.
// Depends on ssort_pkg and ssort_cell.
// Throughput: one value per cycle while filling; each value is registered in its cell.
// Output: first result in the cycle after the last-marked transfer; the batch
// then drains from cell 0 in ascending order, busy high until its final result.
// Reset clears every cell's occupancy and the overflow flag; the receiver cannot stall.
`timescale 1ns / 1ps

module stable_ascending_sorter
    import ssort_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic signed [WORD_W-1:0] value,
    input  logic         last,
    output logic         valid,
    output logic signed [WORD_W-1:0] sorted_value,
    output logic         final_res,
    output logic         dropped
);

    cell_link_t links [DEPTH];
    cell_link_t prevs [DEPTH];
    cell_link_t nexts [DEPTH];
    cell_cmd_t  cmd;
    logic       accept;
    logic       full;
    logic       draining_reg;
    logic       draining_next;
    logic       overflow_reg;
    logic       overflow_next;
    logic       is_final;

    assign accept = start && !busy;
    assign full   = links[DEPTH-1].occ;

    assign cmd = '{insert: accept && !full, drain: draining_reg, new_value: value};

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign prevs[i] = '{occ: 1'b1, gt: 1'b0, value: '0};
            end
            else
            begin : g_body
                assign prevs[i] = links[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_tail
                assign nexts[i] = '{occ: 1'b0, gt: 1'b0, value: '0};
            end
            else
            begin : g_mid
                assign nexts[i] = links[i+1];
            end
            ssort_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .prev_link (prevs[i]),
                .next_link (nexts[i]),
                .link      (links[i])
            );
        end
    endgenerate

    assign is_final = draining_reg && !links[1].occ;

    always_comb
    begin
        draining_next = draining_reg;
        overflow_next = overflow_reg;
        if (accept)
        begin
            // drop on a full chain, flag the batch
            if (full)
            begin
                overflow_next = 1'b1;
            end
            if (last)
            begin
                draining_next = 1'b1;
            end
        end
        else if (is_final)
        begin
            draining_next = 1'b0;
            overflow_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            draining_reg <= draining_next;
            overflow_reg <= overflow_next;
        end
    end

    assign busy         = draining_reg;
    assign valid        = draining_reg;
    assign sorted_value = links[0].value;
    assign final_res    = is_final;
    assign dropped      = overflow_reg;

    a_valid_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> links[0].occ)
        else $error("result strobe with empty head cell");

    a_final_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && final_res) |=> (!busy && !links[0].occ && !dropped))
        else $error("chain not empty after final transfer");

    a_no_result_mid_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !last) |=> !valid)
        else $error("result emitted without last transfer");

    a_fill_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        links[DEPTH-1].occ |-> links[0].occ)
        else $error("occupancy not contiguous from head");

endmodule

@@ tb/tb_stable_ascending_sorter.sv @@
// Self-checking testbench for the stable ascending sorter: directed table, fixed
// overflow batches, then random batches with random sender gaps.
// Depends on ssort_pkg and the stable_ascending_sorter RTL.
`timescale 1ns / 1ps

module tb_stable_ascending_sorter;
    import ssort_pkg::*;

    localparam word_t WORD_MIN    = {1'b1, {(WORD_W-1){1'b0}}};
    localparam word_t WORD_MAX    = ~WORD_MIN;
    localparam int    CYCLE_LIMIT = 200000;
    localparam int    RAND_ITEMS  = 80;
    localparam int    N_ROWS      = 21;

    typedef struct {
        word_t v;
        logic  fin;
        logic  drp;
    } sorted_res_t;

    typedef struct {
        word_t v;
        logic  lst;
        logic  typed;
        word_t ev;
    } stim_row_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    word_t value;
    logic  last;
    logic  valid;
    word_t sorted_value;
    logic  final_res;
    logic  dropped;

    logic  row_typed;
    word_t row_expect;

    word_t       held_cells [DEPTH];
    int          held_count;
    logic        batch_overflow;
    sorted_res_t pending_results [$];
    stim_row_t   directed_rows [N_ROWS];

    int errors;
    int cycle_count;
    int n_transfers;
    int n_results;
    int n_batches;
    int n_overflow_batches;

    stable_ascending_sorter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last         (last),
        .valid        (valid),
        .sorted_value (sorted_value),
        .final_res    (final_res),
        .dropped      (dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic sort_transfer(input word_t v, input logic lst, input logic typed,
                                 input word_t tv);
        int          pos;
        sorted_res_t r;
        if (held_count < DEPTH)
        begin
            pos = held_count;
            while (pos > 0 && held_cells[pos-1] > v)
            begin
                held_cells[pos] = held_cells[pos-1];
                pos--;
            end
            held_cells[pos] = v;
            held_count++;
        end
        else
            batch_overflow = 1'b1;
        if (lst)
        begin
            if (typed)
            begin
                r.v   = tv;
                r.fin = 1'b1;
                r.drp = 1'b0;
                pending_results.push_back(r);
            end
            else
            begin
                for (int k = 0; k < held_count; k++)
                begin
                    r.v   = held_cells[k];
                    r.fin = (k == held_count - 1);
                    r.drp = batch_overflow;
                    pending_results.push_back(r);
                end
            end
            n_batches++;
            if (batch_overflow)
                n_overflow_batches++;
            held_count     = 0;
            batch_overflow = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        sorted_res_t e;
        if (rst_n)
        begin
            if (valid)
            begin
                n_results++;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual %0d fin %0b drp %0b",
                             $time, sorted_value, final_res, dropped);
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (sorted_value !== e.v || final_res !== e.fin || dropped !== e.drp)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected %0d fin %0b drp %0b, actual %0d fin %0b drp %0b",
                                 $time, e.v, e.fin, e.drp, sorted_value, final_res, dropped);
                    end
                end
            end
            if (start && !busy)
            begin
                n_transfers++;
                sort_transfer(value, last, row_typed, row_expect);
            end
        end
    end

    function automatic word_t rand_word();
        word_t w;
        case ($urandom_range(0, 3))
            0: w = word_t'($urandom_range(0, 8)) - word_t'(4);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: w = WORD_MIN;
                    1: w = WORD_MAX;
                    2: w = '0;
                    default: w = '1;
                endcase
            end
            default: w = word_t'($urandom);
        endcase
        return w;
    endfunction

    // hold start until the transfer is taken; gap cycles of idling go first
    task automatic send_item(input word_t v, input logic lst, input logic typed,
                             input word_t tv, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            value <= word_t'($urandom);
            last  <= 1'($urandom_range(0, 1));
            repeat (gap - 1)
            begin
                @(negedge clk);
                value <= word_t'($urandom);
                last  <= 1'($urandom_range(0, 1));
            end
        end
        @(negedge clk);
        start      <= 1'b1;
        value      <= v;
        last       <= lst;
        row_typed  <= typed;
        row_expect <= tv;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_batch(input int len, input logic no_gaps);
        for (int i = 0; i < len; i++)
            send_item(rand_word(), i == len - 1, 1'b0, '0,
                      no_gaps ? 0 : $urandom_range(0, 14));
    endtask

    initial
    begin
        int rand_sent;
        int len;
        logic no_gaps;

        errors             = 0;
        cycle_count        = 0;
        n_transfers        = 0;
        n_results          = 0;
        n_batches          = 0;
        n_overflow_batches = 0;
        held_count         = 0;
        batch_overflow     = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        value      = '0;
        last       = 1'b0;
        row_typed  = 1'b0;
        row_expect = '0;

        directed_rows = '{
            '{WORD_MIN, 1'b1, 1'b1, WORD_MIN},
            '{WORD_MAX, 1'b1, 1'b1, WORD_MAX},
            '{'0,       1'b1, 1'b1, '0},
            '{'1,       1'b1, 1'b1, '1},
            '{word_t'(1), 1'b1, 1'b1, word_t'(1)},
            '{word_t'(3),    1'b0, 1'b0, '0},
            '{-word_t'(7),   1'b0, 1'b0, '0},
            '{word_t'(3),    1'b0, 1'b0, '0},
            '{WORD_MAX,      1'b0, 1'b0, '0},
            '{WORD_MIN,      1'b1, 1'b0, '0},
            '{word_t'(100),  1'b0, 1'b0, '0},
            '{word_t'(50),   1'b0, 1'b0, '0},
            '{'0,            1'b0, 1'b0, '0},
            '{-word_t'(50),  1'b0, 1'b0, '0},
            '{-word_t'(100), 1'b1, 1'b0, '0},
            '{word_t'(9),    1'b0, 1'b0, '0},
            '{word_t'(9),    1'b0, 1'b0, '0},
            '{word_t'(9),    1'b1, 1'b0, '0},
            '{word_t'(1),    1'b0, 1'b0, '0},
            '{word_t'(2),    1'b0, 1'b0, '0},
            '{word_t'(3),    1'b1, 1'b0, '0}
        };

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].v, directed_rows[i].lst, directed_rows[i].typed,
                      directed_rows[i].ev, $urandom_range(0, 3));
        wait_drained();

        // exactly full, then overflow with the last mark on a discarded transfer
        run_batch(DEPTH, 1'b1);
        run_batch(DEPTH + 1, 1'b0);
        run_batch(DEPTH + 5, 1'b1);
        wait_drained();

        rand_sent = 0;
        while (rand_sent < RAND_ITEMS)
        begin
            if ($urandom_range(0, 19) == 0)
                len = $urandom_range(DEPTH - 2, DEPTH + 6);
            else
                len = $urandom_range(1, 8);
            no_gaps = ($urandom_range(0, 9) < 3);
            run_batch(len, no_gaps);
            rand_sent += len;
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DEPTH + 10) @(posedge clk);
        while (pending_results.size() != 0)
        begin
            sorted_res_t e;
            e = pending_results.pop_front();
            errors++;
            $display("%0t: missing result: expected %0d fin %0b drp %0b, actual none",
                     $time, e.v, e.fin, e.drp);
        end

        $display("Sorted %0d batches (%0d with discarded transfers) from %0d transfers,",
                 n_batches, n_overflow_batches, n_transfers);
        $display("checked %0d results in %0d cycles, %0d errors.",
                 n_results, cycle_count, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
